// ===== design/lpip_pkg.sv =====
package lpip_pkg;

    localparam int COORD_BITS   = 16;
    localparam int MAX_VERTICES = 64;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int DIFF_W       = COORD_BITS + 1;
    localparam int PRESCALE_SH  = 14;
    localparam int XY_W         = DIFF_W + PRESCALE_SH + 3;
    localparam int ANG_W        = 18;
    localparam int ITERS        = 14;
    localparam int IT_W         = $clog2(ITERS);
    localparam int SUM_W        = ANG_W + ADDR_W;

    localparam logic signed [ANG_W-1:0] ANG_PI     = ANG_W'(25736);
    localparam logic signed [ANG_W-1:0] ANG_TWO_PI = ANG_W'(51472);
    localparam logic signed [ANG_W-1:0] ANG_ONE    = ANG_W'(8192);

    localparam logic [1:0] MODE_START  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_TEST   = 2'd2;

    typedef struct packed {
        logic [1:0]                   mode;
        logic signed [COORD_BITS-1:0] coord_x;
        logic signed [COORD_BITS-1:0] coord_y;
    } t_in_item;

    typedef struct packed {
        logic inside_res;
        logic path_overflow;
    } t_out_item;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } t_vertex;

    function automatic logic signed [ANG_W-1:0] atan_tab(input logic [IT_W-1:0] idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            4'd0:    v = ANG_W'(6434);
            4'd1:    v = ANG_W'(3798);
            4'd2:    v = ANG_W'(2007);
            4'd3:    v = ANG_W'(1019);
            4'd4:    v = ANG_W'(511);
            4'd5:    v = ANG_W'(256);
            4'd6:    v = ANG_W'(128);
            4'd7:    v = ANG_W'(64);
            4'd8:    v = ANG_W'(32);
            4'd9:    v = ANG_W'(16);
            4'd10:   v = ANG_W'(8);
            4'd11:   v = ANG_W'(4);
            4'd12:   v = ANG_W'(2);
            4'd13:   v = ANG_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

    // single-step wrap into -pi..pi; inputs stay within +-3*pi
    function automatic logic signed [ANG_W-1:0] wrap_ang(input logic signed [ANG_W:0] a);
        logic signed [ANG_W:0] r;
        r = a;
        if (a > (ANG_W+1)'(ANG_PI)) begin
            r = a - (ANG_W+1)'(ANG_TWO_PI);
        end else if (a < -(ANG_W+1)'(ANG_PI)) begin
            r = a + (ANG_W+1)'(ANG_TWO_PI);
        end
        return r[ANG_W-1:0];
    endfunction

endpackage

// ===== design/lasso_point_in_polygon.sv =====
// Lasso point-in-polygon test. mode 0 starts a new path with the given vertex, mode 1 appends
// a vertex (dropped and flagged in path_overflow once 64 are held), mode 2 tests the point and
// returns one item; mode 3 is taken and ignored. Path items do not leave the idle state. A test
// computes one CORDIC atan2 per vertex on a single shared iterative unit (14 iterations), plus
// one for the closing vertex; an empty path runs none. One item is worked on at a time; a
// finished result waits in the output register while the next item is taken.
module lasso_point_in_polygon (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  lpip_pkg::t_in_item    i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output lpip_pkg::t_out_item   o_out_item
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOAD = 2'd1;
    localparam logic [1:0] S_CORD = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]                                 r_state;
    logic [lpip_pkg::CNT_W-1:0]                 r_count;
    logic                                       r_ovf;
    logic                                       r_first;
    logic [lpip_pkg::ADDR_W-1:0]                r_j;
    logic signed [lpip_pkg::COORD_BITS-1:0]     r_px;
    logic signed [lpip_pkg::COORD_BITS-1:0]     r_py;
    logic signed [lpip_pkg::ANG_W-1:0]          r_prev;
    logic signed [lpip_pkg::SUM_W-1:0]          r_sum;
    logic                                       r_out_valid;
    lpip_pkg::t_out_item                        r_out_item;

    logic                                       w_acc;
    logic                                       w_full;
    logic                                       w_we;
    logic [lpip_pkg::ADDR_W-1:0]                w_waddr;
    lpip_pkg::t_vertex                          w_wdata;
    logic                                       w_re;
    logic [lpip_pkg::ADDR_W-1:0]                w_raddr;
    lpip_pkg::t_vertex                          w_rdata;
    logic                                       w_cord_start;
    logic                                       w_cord_done;
    logic signed [lpip_pkg::ANG_W-1:0]          w_ang;
    logic signed [lpip_pkg::DIFF_W-1:0]         w_dx;
    logic signed [lpip_pkg::DIFF_W-1:0]         w_dy;
    logic [lpip_pkg::CNT_W-1:0]                 w_j_next;
    logic                                       w_last;
    logic signed [lpip_pkg::ANG_W-1:0]          w_diff;
    logic signed [lpip_pkg::SUM_W-1:0]          w_abs;
    logic signed [lpip_pkg::SUM_W-1:0]          w_dist;
    logic signed [lpip_pkg::SUM_W-1:0]          w_dist_abs;
    logic                                       w_inside;
    logic                                       w_out_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_acc      = i_in_valid && o_in_ready;
    assign w_full     = (r_count == lpip_pkg::CNT_W'(lpip_pkg::MAX_VERTICES));

    assign w_we    = w_acc && ((i_in_item.mode == lpip_pkg::MODE_START) ||
                               (i_in_item.mode == lpip_pkg::MODE_APPEND && !w_full));
    assign w_waddr = (i_in_item.mode == lpip_pkg::MODE_START) ? '0
                                                                : r_count[lpip_pkg::ADDR_W-1:0];
    assign w_wdata = '{x: i_in_item.coord_x, y: i_in_item.coord_y};

    assign w_j_next = lpip_pkg::CNT_W'(r_j) + lpip_pkg::CNT_W'(1);
    assign w_last   = !r_first && (w_j_next == r_count);

    always_comb begin
        w_re    = 1'b0;
        w_raddr = '0;
        if (r_state == S_IDLE && w_acc && i_in_item.mode == lpip_pkg::MODE_TEST) begin
            w_re    = (r_count != '0);
            w_raddr = lpip_pkg::ADDR_W'(r_count - lpip_pkg::CNT_W'(1));
        end else if (r_state == S_CORD && w_cord_done && !w_last) begin
            w_re    = 1'b1;
            w_raddr = r_first ? '0 : w_j_next[lpip_pkg::ADDR_W-1:0];
        end
    end

    lpip_vram u_vram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_cord_start = (r_state == S_LOAD);
    assign w_dx = lpip_pkg::DIFF_W'(w_rdata.x) - lpip_pkg::DIFF_W'(r_px);
    assign w_dy = lpip_pkg::DIFF_W'(w_rdata.y) - lpip_pkg::DIFF_W'(r_py);

    lpip_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cord_start),
        .i_dx    (w_dx),
        .i_dy    (w_dy),
        .o_done  (w_cord_done),
        .o_ang   (w_ang)
    );

    assign w_diff = lpip_pkg::wrap_ang((lpip_pkg::ANG_W+1)'(w_ang)
                                       - (lpip_pkg::ANG_W+1)'(r_prev));

    assign w_abs      = (r_sum < 0) ? -r_sum : r_sum;
    assign w_dist     = lpip_pkg::SUM_W'(lpip_pkg::ANG_TWO_PI) - w_abs;
    assign w_dist_abs = (w_dist < 0) ? -w_dist : w_dist;
    assign w_inside   = (w_dist_abs < lpip_pkg::SUM_W'(lpip_pkg::ANG_ONE));
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_first     <= 1'b0;
            r_j         <= '0;
        end else begin
            r_out_valid <= (r_out_valid && !i_out_ready)
                           || (r_state == S_DONE && w_out_free);
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        case (i_in_item.mode)
                            lpip_pkg::MODE_START: begin
                                r_count <= lpip_pkg::CNT_W'(1);
                                r_ovf   <= 1'b0;
                            end
                            lpip_pkg::MODE_APPEND: begin
                                if (w_full) begin
                                    r_ovf <= 1'b1;
                                end else begin
                                    r_count <= r_count + lpip_pkg::CNT_W'(1);
                                end
                            end
                            lpip_pkg::MODE_TEST: begin
                                r_first <= 1'b1;
                                r_j     <= '0;
                                r_state <= (r_count == '0) ? S_DONE : S_LOAD;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_LOAD: begin
                    r_state <= S_CORD;
                end
                S_CORD: begin
                    if (w_cord_done) begin
                        r_first <= 1'b0;
                        if (!r_first) begin
                            r_j <= w_j_next[lpip_pkg::ADDR_W-1:0];
                        end
                        r_state <= w_last ? S_DONE : S_LOAD;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && w_acc && i_in_item.mode == lpip_pkg::MODE_TEST) begin
            r_px  <= i_in_item.coord_x;
            r_py  <= i_in_item.coord_y;
            r_sum <= '0;
        end
        if (r_state == S_CORD && w_cord_done) begin
            r_prev <= w_ang;
            if (!r_first) begin
                r_sum <= r_sum + lpip_pkg::SUM_W'(w_diff);
            end
        end
        if (r_state == S_DONE && w_out_free) begin
            r_out_item <= '{inside_res: w_inside, path_overflow: r_ovf};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= lpip_pkg::CNT_W'(lpip_pkg::MAX_VERTICES))
        else $error("vertex count beyond capacity");

    a_start_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_in_item.mode == lpip_pkg::MODE_START)
        |=> (r_count == lpip_pkg::CNT_W'(1) && !r_ovf))
        else $error("new path did not reset count and flag");

    a_ovf_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovf) |-> $past(w_acc && i_in_item.mode == lpip_pkg::MODE_APPEND && w_full))
        else $error("overflow set without append to full store");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result item raised outside finish step");

endmodule

// ===== design/lpip_vram.sv =====
module lpip_vram (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [lpip_pkg::ADDR_W-1:0]    i_waddr,
    input  lpip_pkg::t_vertex              i_wdata,
    input  logic                           i_re,
    input  logic [lpip_pkg::ADDR_W-1:0]    i_raddr,
    output lpip_pkg::t_vertex              o_rdata
);

    lpip_pkg::t_vertex r_mem [lpip_pkg::MAX_VERTICES];
    lpip_pkg::t_vertex r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/lpip_cordic.sv =====
module lpip_cordic (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic signed [lpip_pkg::DIFF_W-1:0]     i_dx,
    input  logic signed [lpip_pkg::DIFF_W-1:0]     i_dy,
    output logic                                   o_done,
    output logic signed [lpip_pkg::ANG_W-1:0]      o_ang
);

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_RUN  = 2'd1;
    localparam logic [1:0] C_WRAP = 2'd2;

    logic [1:0]                             r_state;
    logic                                   r_done;
    logic [lpip_pkg::IT_W-1:0]              r_it;
    logic signed [lpip_pkg::XY_W-1:0]       r_x;
    logic signed [lpip_pkg::XY_W-1:0]       r_y;
    logic signed [lpip_pkg::ANG_W-1:0]      r_z;
    logic signed [lpip_pkg::ANG_W-1:0]      r_ang;

    logic signed [lpip_pkg::XY_W-1:0]       w_x_in;
    logic signed [lpip_pkg::XY_W-1:0]       w_y_in;
    logic signed [lpip_pkg::XY_W-1:0]       n_x0;
    logic signed [lpip_pkg::XY_W-1:0]       n_y0;
    logic signed [lpip_pkg::ANG_W-1:0]      n_z0;
    logic signed [lpip_pkg::XY_W-1:0]       w_xs;
    logic signed [lpip_pkg::XY_W-1:0]       w_ys;
    logic signed [lpip_pkg::XY_W-1:0]       n_x;
    logic signed [lpip_pkg::XY_W-1:0]       n_y;
    logic signed [lpip_pkg::ANG_W-1:0]      n_z;
    logic                                   w_zero;
    logic                                   w_last;

    assign w_x_in = lpip_pkg::XY_W'(i_dx) <<< lpip_pkg::PRESCALE_SH;
    assign w_y_in = lpip_pkg::XY_W'(i_dy) <<< lpip_pkg::PRESCALE_SH;
    assign w_zero = (i_dx == '0) && (i_dy == '0);
    assign w_last = (r_it == lpip_pkg::IT_W'(lpip_pkg::ITERS - 1));

    // left half plane: rotate by pi first
    always_comb begin
        n_x0 = w_x_in;
        n_y0 = w_y_in;
        n_z0 = '0;
        if (w_x_in < 0) begin
            n_z0 = (w_y_in >= 0) ? lpip_pkg::ANG_PI : -lpip_pkg::ANG_PI;
            n_x0 = -w_x_in;
            n_y0 = -w_y_in;
        end
    end

    always_comb begin
        w_xs = r_x >>> r_it;
        w_ys = r_y >>> r_it;
        if (r_y >= 0) begin
            n_x = r_x + w_ys;
            n_y = r_y - w_xs;
            n_z = r_z + lpip_pkg::atan_tab(r_it);
        end else begin
            n_x = r_x - w_ys;
            n_y = r_y + w_xs;
            n_z = r_z - lpip_pkg::atan_tab(r_it);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
            r_it    <= '0;
        end else begin
            r_done <= (r_state == C_WRAP);
            case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        r_it    <= '0;
                        r_state <= w_zero ? C_WRAP : C_RUN;
                    end
                end
                C_RUN: begin
                    r_it <= r_it + lpip_pkg::IT_W'(1);
                    if (w_last) begin
                        r_state <= C_WRAP;
                    end
                end
                C_WRAP: begin
                    r_state <= C_IDLE;
                end
                default: begin
                    r_state <= C_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == C_IDLE && i_start) begin
            r_x <= n_x0;
            r_y <= n_y0;
            r_z <= w_zero ? '0 : n_z0;
        end else if (r_state == C_RUN) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
        if (r_state == C_WRAP) begin
            r_ang <= lpip_pkg::wrap_ang((lpip_pkg::ANG_W+1)'(r_z));
        end
    end

    assign o_done = r_done;
    assign o_ang  = r_ang;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_state == C_IDLE)
        else $error("cordic started while busy");

    a_done_after_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state == C_WRAP))
        else $error("cordic done without wrap step");

    a_run_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == C_RUN && w_last) |=> r_state == C_WRAP)
        else $error("cordic iteration count wrong");

endmodule
